/* rtl/msca_pkg.sv */
// Shared types, constants and register map of the millisecond clock with alarm.
`default_nettype none
package msca_pkg;

  localparam int MS_PER_SEC    = 1000;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;

  localparam int HOURS_W   = 5;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int MILLIS_W  = 10;
  localparam int LENGTH_W  = 16;
  localparam int STEP_W    = 10;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CLOCK_START_HOURS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLOCK_START_MINUTES = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLOCK_START_SECONDS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALARM_START_HOURS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALARM_START_MINUTES = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ALARM_START_SECONDS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SIGNAL_LENGTH_MS    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ADJUST_STEP_MS      = 3'd7;

  localparam logic [HOURS_W-1:0]   RST_CLOCK_HOURS   = 5'd8;
  localparam logic [MINUTES_W-1:0] RST_CLOCK_MINUTES = 6'd29;
  localparam logic [SECONDS_W-1:0] RST_CLOCK_SECONDS = 6'd59;
  localparam logic [HOURS_W-1:0]   RST_ALARM_HOURS   = 5'd8;
  localparam logic [MINUTES_W-1:0] RST_ALARM_MINUTES = 6'd30;
  localparam logic [SECONDS_W-1:0] RST_ALARM_SECONDS = 6'd0;
  localparam logic [LENGTH_W-1:0]  RST_SIGNAL_LENGTH = 16'd1000;
  localparam logic [STEP_W-1:0]    RST_ADJUST_STEP   = 10'd60;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [MILLIS_W-1:0]  millis;
  } time_t;

  typedef struct packed {
    logic [HOURS_W-1:0]   clock_start_hours;
    logic [MINUTES_W-1:0] clock_start_minutes;
    logic [SECONDS_W-1:0] clock_start_seconds;
    logic [HOURS_W-1:0]   alarm_start_hours;
    logic [MINUTES_W-1:0] alarm_start_minutes;
    logic [SECONDS_W-1:0] alarm_start_seconds;
    logic [LENGTH_W-1:0]  signal_length_ms;
    logic [STEP_W-1:0]    adjust_step_ms;
  } cfg_t;

  typedef struct packed {
    logic  led_on;
    time_t now;
    time_t wake;
  } result_t;

endpackage
`default_nettype wire

/* rtl/msca_regs.sv */
// Configuration register bank behind the APB-style port.
`default_nettype none
module msca_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output msca_pkg::cfg_t           cfg
);

  logic                             wr;
  logic [msca_pkg::REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_start_hours   <= msca_pkg::RST_CLOCK_HOURS;
      cfg.clock_start_minutes <= msca_pkg::RST_CLOCK_MINUTES;
      cfg.clock_start_seconds <= msca_pkg::RST_CLOCK_SECONDS;
      cfg.alarm_start_hours   <= msca_pkg::RST_ALARM_HOURS;
      cfg.alarm_start_minutes <= msca_pkg::RST_ALARM_MINUTES;
      cfg.alarm_start_seconds <= msca_pkg::RST_ALARM_SECONDS;
      cfg.signal_length_ms    <= msca_pkg::RST_SIGNAL_LENGTH;
      cfg.adjust_step_ms      <= msca_pkg::RST_ADJUST_STEP;
    end else if (wr) begin
      unique case (idx)
        msca_pkg::REG_CLOCK_START_HOURS:
          cfg.clock_start_hours <= pwdata[msca_pkg::HOURS_W-1:0];
        msca_pkg::REG_CLOCK_START_MINUTES:
          cfg.clock_start_minutes <= pwdata[msca_pkg::MINUTES_W-1:0];
        msca_pkg::REG_CLOCK_START_SECONDS:
          cfg.clock_start_seconds <= pwdata[msca_pkg::SECONDS_W-1:0];
        msca_pkg::REG_ALARM_START_HOURS:
          cfg.alarm_start_hours <= pwdata[msca_pkg::HOURS_W-1:0];
        msca_pkg::REG_ALARM_START_MINUTES:
          cfg.alarm_start_minutes <= pwdata[msca_pkg::MINUTES_W-1:0];
        msca_pkg::REG_ALARM_START_SECONDS:
          cfg.alarm_start_seconds <= pwdata[msca_pkg::SECONDS_W-1:0];
        msca_pkg::REG_SIGNAL_LENGTH_MS:
          cfg.signal_length_ms <= pwdata[msca_pkg::LENGTH_W-1:0];
        msca_pkg::REG_ADJUST_STEP_MS:
          cfg.adjust_step_ms <= pwdata[msca_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      msca_pkg::REG_CLOCK_START_HOURS:
        prdata[msca_pkg::HOURS_W-1:0] = cfg.clock_start_hours;
      msca_pkg::REG_CLOCK_START_MINUTES:
        prdata[msca_pkg::MINUTES_W-1:0] = cfg.clock_start_minutes;
      msca_pkg::REG_CLOCK_START_SECONDS:
        prdata[msca_pkg::SECONDS_W-1:0] = cfg.clock_start_seconds;
      msca_pkg::REG_ALARM_START_HOURS:
        prdata[msca_pkg::HOURS_W-1:0] = cfg.alarm_start_hours;
      msca_pkg::REG_ALARM_START_MINUTES:
        prdata[msca_pkg::MINUTES_W-1:0] = cfg.alarm_start_minutes;
      msca_pkg::REG_ALARM_START_SECONDS:
        prdata[msca_pkg::SECONDS_W-1:0] = cfg.alarm_start_seconds;
      msca_pkg::REG_SIGNAL_LENGTH_MS:
        prdata[msca_pkg::LENGTH_W-1:0] = cfg.signal_length_ms;
      msca_pkg::REG_ADJUST_STEP_MS:
        prdata[msca_pkg::STEP_W-1:0] = cfg.adjust_step_ms;
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/msca_advance.sv */
// Time-of-day adder: adds milliseconds and ripples the carries up to hours.
`default_nettype none
module msca_advance (
  input  wire msca_pkg::time_t             t_in,
  input  wire logic [msca_pkg::STEP_W-1:0] add,
  output msca_pkg::time_t                  t_out
);

  localparam int MS_SUM_W = msca_pkg::MILLIS_W + 1;
  localparam int S_SUM_W  = msca_pkg::SECONDS_W + 1;
  localparam int M_SUM_W  = msca_pkg::MINUTES_W + 1;
  localparam int H_SUM_W  = msca_pkg::HOURS_W + 1;

  logic [MS_SUM_W-1:0] ms_sum;
  logic [1:0]          ms_carry;
  logic [MS_SUM_W-1:0] ms_sub;
  logic [S_SUM_W-1:0]  s_sum;
  logic [M_SUM_W-1:0]  m_sum;
  logic [H_SUM_W-1:0]  h_sum;

  always_comb begin
    ms_sum = {1'b0, t_in.millis} + MS_SUM_W'(add);
    if (ms_sum >= MS_SUM_W'(2 * msca_pkg::MS_PER_SEC)) begin
      ms_carry = 2'd2;
      ms_sub   = MS_SUM_W'(2 * msca_pkg::MS_PER_SEC);
    end else if (ms_sum >= MS_SUM_W'(msca_pkg::MS_PER_SEC)) begin
      ms_carry = 2'd1;
      ms_sub   = MS_SUM_W'(msca_pkg::MS_PER_SEC);
    end else begin
      ms_carry = 2'd0;
      ms_sub   = '0;
    end
    s_sum = {1'b0, t_in.seconds} + S_SUM_W'(ms_carry);
    m_sum = {1'b0, t_in.minutes} + M_SUM_W'(1);
    h_sum = {1'b0, t_in.hours} + H_SUM_W'(1);

    t_out        = t_in;
    t_out.millis = msca_pkg::MILLIS_W'(ms_sum - ms_sub);
    if (ms_carry != 2'd0) begin
      t_out.seconds = s_sum[msca_pkg::SECONDS_W-1:0];
      if (s_sum >= S_SUM_W'(msca_pkg::SEC_PER_MIN)) begin
        t_out.seconds = msca_pkg::SECONDS_W'(s_sum - S_SUM_W'(msca_pkg::SEC_PER_MIN));
        t_out.minutes = m_sum[msca_pkg::MINUTES_W-1:0];
        if (m_sum >= M_SUM_W'(msca_pkg::MIN_PER_HOUR)) begin
          t_out.minutes = msca_pkg::MINUTES_W'(m_sum - M_SUM_W'(msca_pkg::MIN_PER_HOUR));
          t_out.hours   = h_sum[msca_pkg::HOURS_W-1:0];
          if (h_sum >= H_SUM_W'(msca_pkg::HOURS_PER_DAY)) begin
            t_out.hours = msca_pkg::HOURS_W'(h_sum - H_SUM_W'(msca_pkg::HOURS_PER_DAY));
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/msca_tick.sv */
// Clock, alarm and signal state with the next-state logic for one tick.
`default_nettype none
module msca_tick (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire logic           restart,
  input  wire logic           pressed,
  input  wire msca_pkg::cfg_t cfg,
  output msca_pkg::result_t   result
);

  msca_pkg::time_t                clk_time, clk_time_next, clk_adv;
  msca_pkg::time_t                alm_time, alm_time_next, alm_adv;
  logic                           signalling, signalling_next;
  logic [msca_pkg::LENGTH_W-1:0]  signal_ticks, signal_ticks_next, ticks_inc;

  msca_advance u_clk_adv (
    .t_in  (clk_time),
    .add   (msca_pkg::STEP_W'(1)),
    .t_out (clk_adv)
  );

  msca_advance u_alm_adv (
    .t_in  (alm_time),
    .add   (cfg.adjust_step_ms),
    .t_out (alm_adv)
  );

  assign ticks_inc = signal_ticks + msca_pkg::LENGTH_W'(1);

  always_comb begin
    if (restart) begin
      clk_time_next.hours   = cfg.clock_start_hours;
      clk_time_next.minutes = cfg.clock_start_minutes;
      clk_time_next.seconds = cfg.clock_start_seconds;
      clk_time_next.millis  = '0;
      alm_time_next.hours   = cfg.alarm_start_hours;
      alm_time_next.minutes = cfg.alarm_start_minutes;
      alm_time_next.seconds = cfg.alarm_start_seconds;
      alm_time_next.millis  = '0;
      signalling_next       = 1'b0;
      signal_ticks_next     = '0;
    end else begin
      clk_time_next     = clk_adv;
      signalling_next   = signalling;
      signal_ticks_next = signal_ticks;
      if (signalling) begin
        signal_ticks_next = ticks_inc;
        if (ticks_inc == cfg.signal_length_ms) begin
          signalling_next   = 1'b0;
          signal_ticks_next = '0;
        end
      end
      if (clk_adv.hours == alm_time.hours && clk_adv.minutes == alm_time.minutes &&
          clk_adv.seconds == '0) begin
        signalling_next = 1'b1;
      end
      alm_time_next = pressed ? alm_adv : alm_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_time.hours   <= msca_pkg::RST_CLOCK_HOURS;
      clk_time.minutes <= msca_pkg::RST_CLOCK_MINUTES;
      clk_time.seconds <= msca_pkg::RST_CLOCK_SECONDS;
      clk_time.millis  <= '0;
      alm_time.hours   <= msca_pkg::RST_ALARM_HOURS;
      alm_time.minutes <= msca_pkg::RST_ALARM_MINUTES;
      alm_time.seconds <= msca_pkg::RST_ALARM_SECONDS;
      alm_time.millis  <= '0;
      signalling       <= 1'b0;
      signal_ticks     <= '0;
    end else if (fire) begin
      clk_time     <= clk_time_next;
      alm_time     <= alm_time_next;
      signalling   <= signalling_next;
      signal_ticks <= signal_ticks_next;
    end
  end

  assign result.led_on = signalling_next;
  assign result.now    = clk_time_next;
  assign result.wake   = alm_time_next;

  // counter runs only while signalling
  a_ticks_idle: assert property (@(posedge clk) disable iff (rst)
    !signalling |-> signal_ticks == '0)
    else $error("signal counter running while the signal is off");

  a_clk_millis: assert property (@(posedge clk) disable iff (rst)
    clk_time.millis < msca_pkg::MILLIS_W'(msca_pkg::MS_PER_SEC))
    else $error("clock milliseconds out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(clk_time) && $stable(alm_time) && $stable(signal_ticks))
    else $error("state changed without a tick");

endmodule
`default_nettype wire

/* rtl/ms_clock_with_alarm.sv */
// Top level of the millisecond clock with alarm: input word register, tick logic, result register.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: button_pressed; tuser: restart
//  m_       | out       | m_tvalid/m_tready  | tdata: led_on, now time, wake time
//  apb      | in        | psel/penable       | eight start, length and step registers
//
//  One word in and one word out per cycle unless the output stalls; each word passes the input
//  register, then the result register; the tick adder and carry ripple into hours lie between.
//  rst is synchronous and loads the power-on start times and register values.
//  A stalled result word holds; a full input register then holds too, and s_tready drops.
`default_nettype none
module ms_clock_with_alarm (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] button_pressed, [7:1] zero
  input  wire logic        s_tuser,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [0] led_on, [5:1] now_hours, [11:6] now_minutes,
                                      // [17:12] now_seconds, [27:18] now_millis,
                                      // [32:28] wake_hours, [38:33] wake_minutes,
                                      // [44:39] wake_seconds, [47:45] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int MILLIS_LSB = 1 + msca_pkg::HOURS_W + msca_pkg::MINUTES_W + msca_pkg::SECONDS_W;

  msca_pkg::cfg_t    cfg;
  msca_pkg::result_t result;
  logic              in_valid;
  logic              in_restart;
  logic              in_pressed;
  logic              out_free;
  logic              fire;

  msca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msca_tick u_tick (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .restart (in_restart),
    .pressed (in_pressed),
    .cfg     (cfg),
    .result  (result)
  );

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_restart <= s_tuser;
      in_pressed <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000,
                  result.wake.seconds, result.wake.minutes, result.wake.hours,
                  result.now.millis, result.now.seconds, result.now.minutes,
                  result.now.hours, result.led_on};
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid)
    else $error("input word lost while the result was stalled");

  a_restart_led: assert property (@(posedge clk) disable iff (rst)
    fire && in_restart |=> !m_tdata[0] && m_tdata[MILLIS_LSB +: msca_pkg::MILLIS_W] == '0)
    else $error("restart did not clear the signal and milliseconds");

  a_out_millis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[MILLIS_LSB +: msca_pkg::MILLIS_W] <
                 msca_pkg::MILLIS_W'(msca_pkg::MS_PER_SEC))
    else $error("reported milliseconds out of range");

endmodule
`default_nettype wire
